// File: sv/u8d_pkg.sv
`timescale 1ns / 1ps
package u8d_pkg;

	localparam int unsigned CP_W        = 21;
	localparam int unsigned MAX_RES     = 4;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CP_W-1:0] MAX_SCALAR = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
	localparam logic [CP_W-1:0] MIN_LEN2   = 21'h000080;
	localparam logic [CP_W-1:0] MIN_LEN3   = 21'h000800;
	localparam logic [CP_W-1:0] MIN_LEN4   = 21'h010000;

	// Sequence lengths announced by a lead byte
	localparam logic [2:0] LEN_BAD = 3'd0;
	localparam logic [2:0] LEN_1   = 3'd1;
	localparam logic [2:0] LEN_2   = 3'd2;
	localparam logic [2:0] LEN_3   = 3'd3;
	localparam logic [2:0] LEN_4   = 3'd4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} in_t;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            is_raw_byte;
		logic            run_last;
	} out_t;

	// One result without its run marker
	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            is_raw_byte;
	} res_t;

	// All results caused by one accepted byte
	typedef struct packed {
		logic [1:0]               last_idx;
		res_t [MAX_RES-1:0]       res;
	} step_t;

	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		if (b[7] == 1'b0) len = LEN_1;
		else if (b[7:5] == 3'b110) len = LEN_2;
		else if (b[7:4] == 4'b1110) len = LEN_3;
		else if (b[7:3] == 5'b11110) len = LEN_4;
		else len = LEN_BAD;
		return len;
	endfunction

	function automatic logic is_cont(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

endpackage

// File: sv/u8d_front.sv
`timescale 1ns / 1ps
module u8d_front import u8d_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  in_t   in_item,
	output logic  step_valid,
	output step_t step
);

	logic [7:0] held_q [0:2];
	logic [1:0] held_cnt_q;
	logic [7:0] held_d [0:2];
	logic [1:0] held_cnt_d;
	logic [2:0] res_cnt;

	// Scan the held bytes plus the new byte, at most four results per pass
	always_comb begin : scan
		logic [7:0]      buf_b [0:7];
		logic [2:0]      n;
		logic [2:0]      pos;
		logic            stop;
		logic [7:0]      lead;
		logic [2:0]      len;
		logic [2:0]      avail;
		logic [2:0]      upto;
		logic            bad;
		logic [CP_W-1:0] v;
		logic [CP_W-1:0] vmin;
		logic [7:0]      b1;
		logic [7:0]      b2;
		logic [7:0]      b3;

		for (int i = 0; i < 8; i++) buf_b[i] = 8'h00;
		for (int i = 0; i < 3; i++) buf_b[i] = held_q[i];
		buf_b[{1'b0, held_cnt_q}] = in_item.in_byte;
		n       = {1'b0, held_cnt_q} + 3'd1;
		pos     = 3'd0;
		stop    = 1'b0;
		res_cnt = 3'd0;
		step    = '0;

		for (int it = 0; it < MAX_RES; it++) begin
			lead  = buf_b[pos];
			len   = lead_len(lead);
			avail = n - pos;
			upto  = (avail < len) ? avail : len;
			b1    = buf_b[3'(pos + 3'd1)];
			b2    = buf_b[3'(pos + 3'd2)];
			b3    = buf_b[3'(pos + 3'd3)];
			bad   = 1'b0;
			v     = '0;
			vmin  = '0;
			if (!stop && pos < n) begin
				if (len == LEN_BAD || len == LEN_1) begin
					step.res[res_cnt[1:0]] = '{code_point: {13'd0, lead},
						is_raw_byte: (len == LEN_BAD)};
					res_cnt = res_cnt + 3'd1;
					pos     = pos + 3'd1;
				end else begin
					if (upto > 3'd1 && !is_cont(b1)) bad = 1'b1;
					if (upto > 3'd2 && !is_cont(b2)) bad = 1'b1;
					if (upto > 3'd3 && !is_cont(b3)) bad = 1'b1;
					if (!bad && avail < len) begin
						if (!in_item.end_of_text) stop = 1'b1;
						else bad = 1'b1;
					end
					if (!stop && !bad) begin
						unique case (len)
							LEN_2: begin
								v    = {10'd0, lead[4:0], b1[5:0]};
								vmin = MIN_LEN2;
							end
							LEN_3: begin
								v    = {5'd0, lead[3:0], b1[5:0], b2[5:0]};
								vmin = MIN_LEN3;
							end
							LEN_4: begin
								v    = {lead[2:0], b1[5:0], b2[5:0], b3[5:0]};
								vmin = MIN_LEN4;
							end
							default: begin
								v    = '0;
								vmin = '0;
							end
						endcase
						if (v < vmin || v > MAX_SCALAR || (v >= SURR_LO && v <= SURR_HI))
							bad = 1'b1;
					end
					if (!stop) begin
						if (bad) begin
							step.res[res_cnt[1:0]] = '{code_point: {13'd0, lead},
								is_raw_byte: 1'b1};
							pos = pos + 3'd1;
						end else begin
							step.res[res_cnt[1:0]] = '{code_point: v, is_raw_byte: 1'b0};
							pos = pos + len;
						end
						res_cnt = res_cnt + 3'd1;
					end
				end
			end
		end

		held_cnt_d = 2'(n - pos);
		for (int i = 0; i < 3; i++) held_d[i] = buf_b[3'(pos + 3'(i))];
		step.last_idx = 2'(res_cnt - 3'd1);
	end

	assign step_valid = accept && (res_cnt != 3'd0);

	// Hold the pending sequence between bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
		end else if (accept) begin
			held_cnt_q <= held_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < 3; i++) held_q[i] <= held_d[i];
		end
	end

endmodule

// File: sv/u8d_queue.sv
`timescale 1ns / 1ps
module u8d_queue import u8d_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  step_t wr_data,
	output logic  full,
	input  logic  rd_en,
	output step_t rd_data,
	output logic  empty
);

	step_t             slot_q [0:QUEUE_DEPTH-1];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_rd) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_wr && !do_rd) cnt_q <= cnt_q + QCNT_W'(1);
			else if (do_rd && !do_wr) cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	// Store the step entry
	always_ff @(posedge clk) begin
		if (do_wr) slot_q[wr_ptr_q] <= wr_data;
	end

endmodule

// File: sv/u8d_back.sv
`timescale 1ns / 1ps
module u8d_back import u8d_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_empty,
	input  step_t q_head,
	output logic  q_pop,
	output logic  empty,
	input  logic  pop,
	output out_t  out_item
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	out_t       out_q;
	logic       load;
	logic       at_last;

	assign at_last  = (idx_q == q_head.last_idx);
	assign load     = !q_empty && (!out_valid_q || pop);
	assign q_pop    = load && at_last;
	assign empty    = !out_valid_q;
	assign out_item = out_q;

	// Walk head entry results, one per cycle unless stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= at_last ? 2'd0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.code_point  <= q_head.res[idx_q].code_point;
			out_q.is_raw_byte <= q_head.res[idx_q].is_raw_byte;
			out_q.run_last    <= at_last;
		end
	end

endmodule

// File: sv/utf8_validating_decoder.sv
`timescale 1ns / 1ps
// UTF-8 decoder with validation. One byte is taken per cycle whenever full is low; the
// front scans it together with up to three held bytes in that same cycle and writes its
// results (up to four), if any, as one entry into a four-entry queue. The back walks
// the queue and delivers one result per cycle unless pop is low; plain text sustains
// one byte and one result per cycle under that condition. A byte's first result
// passes through a queue slot and the output register before it shows on out_item.
// Full rises only once the queue holds four pending entries, which happens after bytes
// that cause several results each or a stalled pop.
module utf8_validating_decoder import u8d_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  in_t  in_item,
	output logic empty,
	input  logic pop,
	output out_t out_item
);

	logic  accept;
	logic  step_valid;
	step_t step;
	step_t q_head;
	logic  q_empty;
	logic  q_pop;

	assign accept = push && !full;

	u8d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_item    (in_item),
		.step_valid (step_valid),
		.step       (step)
	);

	u8d_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (step_valid),
		.wr_data (step),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (q_head),
		.empty   (q_empty)
	);

	u8d_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item)
	);

endmodule

// File: sv/u8d_checker.sv
`timescale 1ns / 1ps
module u8d_checker import u8d_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic full,
	input logic empty,
	input logic pop,
	input out_t out_item
);

	// Raw literals are always single non-ASCII bytes
	a_raw_is_high_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_item.is_raw_byte) |->
			(out_item.code_point[20:8] == '0 && out_item.code_point[7] == 1'b1))
		else $error("raw literal outside 80-FF");

	// Decoded values are Unicode scalar values
	a_scalar_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !out_item.is_raw_byte) |->
			(out_item.code_point <= MAX_SCALAR &&
			 !(out_item.code_point >= SURR_LO && out_item.code_point <= SURR_HI)))
		else $error("decoded value is not a scalar value");

	// A stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_item)))
		else $error("result changed while stalled");

	// Nothing can be waiting and the input is open right after reset releases
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> (empty && !full))
		else $error("result present or input blocked after reset");

endmodule

bind utf8_validating_decoder u8d_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.full     (full),
	.empty    (empty),
	.pop      (pop),
	.out_item (out_item)
);
